// ----- rtl/vcsa_pkg.sv -----
// ----------------------------------------------------------------------------
// vcsa_pkg
// Shared widths, codes and types of the Voronoi centroid span accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package vcsa_pkg;

   localparam int MAX_GENERATORS = 4096;
   localparam int MAX_WIDTH      = 4096;
   localparam int MAX_HEIGHT     = 4096;

   // field widths
   localparam int OP_W        = 2;
   localparam int GEN_W       = 12;
   localparam int DENS_W      = 16;
   localparam int DIM_W       = 13;
   localparam int POS_W       = 12;
   localparam int SPAN_MASS_W = 28;
   localparam int SPAN_XMOM_W = 40;
   localparam int MASS_W      = 40;
   localparam int MOM_W       = 52;
   localparam int XPROD_W     = POS_W + DENS_W;
   localparam int YPROD_W     = POS_W + SPAN_MASS_W;

   // one carry bit above the stored width for saturation
   localparam int MASS_SUM_W  = MASS_W + 1;
   localparam int MOM_SUM_W   = MOM_W + 1;

   localparam int GEN_AW      = $clog2(MAX_GENERATORS);

   localparam int CMDQ_DEPTH  = 4;
   localparam int CMDQ_AW     = $clog2(CMDQ_DEPTH);

   localparam int CSR_IDX_W   = 2;

   localparam logic [DIM_W-1:0] IMAGE_WIDTH_RESET  = DIM_W'(4096);
   localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RESET = DIM_W'(4096);

   // input opcodes
   localparam logic [OP_W-1:0] OP_PIXEL      = 2'd0;
   localparam logic [OP_W-1:0] OP_READ       = 2'd1;
   localparam logic [OP_W-1:0] OP_READ_CLEAR = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   typedef enum logic [1:0] {
      CMD_ADD,
      CMD_READ,
      CMD_READ_CLEAR
   } cmd_kind_type;

   // one entry of the queue between span tracker and accumulator
   typedef struct packed {
      cmd_kind_type             kind;
      logic [GEN_W-1:0]         label;
      logic [POS_W-1:0]         row;
      logic [SPAN_MASS_W-1:0]   mass;
      logic [SPAN_XMOM_W-1:0]   xmom;
   } cmd_type;

   // one accumulator memory word
   typedef struct packed {
      logic [MASS_W-1:0] mass;
      logic [MOM_W-1:0]  xmom;
      logic [MOM_W-1:0]  ymom;
   } store_type;

   localparam int STORE_W = $bits(store_type);

endpackage

`default_nettype wire

// ----- rtl/vcsa_ram.sv -----
// ----------------------------------------------------------------------------
// vcsa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module vcsa_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]        wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/vcsa_front.sv -----
// ----------------------------------------------------------------------------
// vcsa_front
// Span tracker: position counters, open span sums, configuration registers.
// Turns pixels into span-close commands and reads into read commands.
// ----------------------------------------------------------------------------
`default_nettype none

module vcsa_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_push,
   output logic                                 req_full,
   input  wire logic [vcsa_pkg::OP_W-1:0]       req_opcode,
   input  wire logic [vcsa_pkg::DENS_W-1:0]     req_density,
   input  wire logic [vcsa_pkg::GEN_W-1:0]      req_generator_index,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [vcsa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [vcsa_pkg::DIM_W-1:0]      csr_wdata,
   input  wire logic                            store_clearing,
   input  wire logic                            cmdq_full,
   output logic                                 cmd_push,
   output vcsa_pkg::cmd_type                    cmd_data
);

   import vcsa_pkg::*;

   logic [DIM_W-1:0]        width_ff, width_in;
   logic [DIM_W-1:0]        height_ff, height_in;
   logic [POS_W-1:0]        col_ff, col_in;
   logic [POS_W-1:0]        row_ff, row_in;
   logic                    open_ff, open_in;
   logic [GEN_W-1:0]        label_ff, label_in;
   logic [SPAN_MASS_W-1:0]  smass_ff, smass_in;
   logic [SPAN_XMOM_W-1:0]  sxmom_ff, sxmom_in;
   logic                    pend_valid_ff, pend_valid_in;
   cmd_type                 pend_cmd_ff, pend_cmd_in;

   logic [DIM_W-1:0]        w_eff, h_eff;
   logic [DIM_W-1:0]        col_next, row_next;
   logic                    row_end, row_wrap;
   logic                    close_old, keep;
   logic                    accept;
   logic [XPROD_W-1:0]      prod_x;
   logic [SPAN_MASS_W-1:0]  mass_n;
   logic [SPAN_XMOM_W-1:0]  xmom_n;
   cmd_type                 old_cmd, new_cmd, read_cmd;

   assign csr_ready = 1'b1;
   assign req_full  = store_clearing || pend_valid_ff || cmdq_full;
   assign accept    = req_push && !req_full;

   // registers used clamped, zero acting as one
   always_comb begin
      if (width_ff == '0) begin
         w_eff = DIM_W'(1);
      end else if (width_ff > DIM_W'(MAX_WIDTH)) begin
         w_eff = DIM_W'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      if (height_ff == '0) begin
         h_eff = DIM_W'(1);
      end else if (height_ff > DIM_W'(MAX_HEIGHT)) begin
         h_eff = DIM_W'(MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
   end

   assign col_next  = {1'b0, col_ff} + DIM_W'(1);
   assign row_next  = {1'b0, row_ff} + DIM_W'(1);
   assign row_end   = col_next >= w_eff;
   assign row_wrap  = row_next >= h_eff;

   assign close_old = open_ff && (req_generator_index != label_ff);
   assign keep      = open_ff && !close_old;

   assign prod_x = XPROD_W'(col_ff) * XPROD_W'(req_density);
   assign mass_n = (keep ? smass_ff : '0) + SPAN_MASS_W'(req_density);
   assign xmom_n = (keep ? sxmom_ff : '0) + SPAN_XMOM_W'(prod_x);

   // a span never crosses a row, so its row is the current row counter
   always_comb begin
      old_cmd.kind  = CMD_ADD;
      old_cmd.label = label_ff;
      old_cmd.row   = row_ff;
      old_cmd.mass  = smass_ff;
      old_cmd.xmom  = sxmom_ff;

      new_cmd.kind  = CMD_ADD;
      new_cmd.label = req_generator_index;
      new_cmd.row   = row_ff;
      new_cmd.mass  = mass_n;
      new_cmd.xmom  = xmom_n;

      read_cmd.kind  = (req_opcode == OP_READ_CLEAR) ? CMD_READ_CLEAR : CMD_READ;
      read_cmd.label = req_generator_index;
      read_cmd.row   = '0;
      read_cmd.mass  = '0;
      read_cmd.xmom  = '0;
   end

   always_comb begin
      width_in      = width_ff;
      height_in     = height_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      open_in       = open_ff;
      label_in      = label_ff;
      smass_in      = smass_ff;
      sxmom_in      = sxmom_ff;
      pend_valid_in = pend_valid_ff;
      pend_cmd_in   = pend_cmd_ff;
      cmd_push      = 1'b0;
      cmd_data      = pend_cmd_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_wdata;
            CSR_IMAGE_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end

      if (pend_valid_ff) begin
         if (!cmdq_full) begin
            cmd_push      = 1'b1;
            pend_valid_in = 1'b0;
         end
      end else if (accept) begin
         case (req_opcode)
            OP_PIXEL: begin
               // label change closes the old span; row end closes the new one
               if (close_old) begin
                  cmd_push = 1'b1;
                  cmd_data = old_cmd;
                  if (row_end) begin
                     pend_valid_in = 1'b1;
                     pend_cmd_in   = new_cmd;
                  end
               end else if (row_end) begin
                  cmd_push = 1'b1;
                  cmd_data = new_cmd;
               end
               if (row_end) begin
                  open_in  = 1'b0;
                  smass_in = '0;
                  sxmom_in = '0;
                  col_in   = '0;
                  row_in   = row_wrap ? '0 : row_next[POS_W-1:0];
               end else begin
                  open_in  = 1'b1;
                  label_in = req_generator_index;
                  smass_in = mass_n;
                  sxmom_in = xmom_n;
                  col_in   = col_next[POS_W-1:0];
               end
            end
            OP_READ, OP_READ_CLEAR: begin
               cmd_push = 1'b1;
               cmd_data = read_cmd;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= IMAGE_WIDTH_RESET;
         height_ff     <= IMAGE_HEIGHT_RESET;
         col_ff        <= '0;
         row_ff        <= '0;
         open_ff       <= 1'b0;
         label_ff      <= '0;
         smass_ff      <= '0;
         sxmom_ff      <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         width_ff      <= width_in;
         height_ff     <= height_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         open_ff       <= open_in;
         label_ff      <= label_in;
         smass_ff      <= smass_in;
         sxmom_ff      <= sxmom_in;
         pend_valid_ff <= pend_valid_in;
      end
      pend_cmd_ff <= pend_cmd_in;
   end

endmodule

`default_nettype wire

// ----- rtl/vcsa_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// vcsa_cmd_fifo
// Short command queue between the span tracker and the accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module vcsa_cmd_fifo (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire vcsa_pkg::cmd_type push_data,
   output logic             full,
   input  wire logic        pop,
   output logic             empty,
   output vcsa_pkg::cmd_type pop_data
);

   import vcsa_pkg::*;

   cmd_type              entry_ff [CMDQ_DEPTH];
   logic [CMDQ_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_AW:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign full     = count_ff == (CMDQ_AW+1)'(CMDQ_DEPTH);
   assign empty    = count_ff == '0;
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + CMDQ_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + CMDQ_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (CMDQ_AW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (CMDQ_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/vcsa_back.sv -----
// ----------------------------------------------------------------------------
// vcsa_back
// Accumulator: per-generator store with saturating read-modify-write,
// read and read-and-clear, result register and clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module vcsa_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        cmd_empty,
   input  wire vcsa_pkg::cmd_type           cmd_data,
   output logic                             cmd_pop,
   output logic                             store_clearing,
   input  wire logic                        rsp_pop,
   output logic                             rsp_empty,
   output logic [vcsa_pkg::GEN_W-1:0]       rsp_read_index,
   output logic [vcsa_pkg::MASS_W-1:0]      rsp_mass,
   output logic [vcsa_pkg::MOM_W-1:0]       rsp_moment_x,
   output logic [vcsa_pkg::MOM_W-1:0]       rsp_moment_y
);

   import vcsa_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_MERGE
   } state_type;

   state_type            state_ff, state_in;
   logic [GEN_AW-1:0]    clr_addr_ff, clr_addr_in;
   cmd_type              cmd_ff, cmd_in;
   store_type            acc_ff, acc_in;
   logic [YPROD_W-1:0]   yprod_ff, yprod_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [GEN_W-1:0]     rsp_index_ff, rsp_index_in;
   store_type            rsp_word_ff, rsp_word_in;

   logic                 ram_wr_en, ram_rd_en;
   logic [GEN_AW-1:0]    ram_wr_addr, ram_rd_addr;
   logic [STORE_W-1:0]   ram_wr_data, ram_rd_data;
   store_type            rd_word, wr_word;

   logic                 in_range;
   logic [MASS_SUM_W-1:0] mass_sum;
   logic [MOM_SUM_W-1:0]  xmom_sum, ymom_sum;
   logic                 rsp_space;

   vcsa_ram #(
      .DATA_W (STORE_W),
      .DEPTH  (MAX_GENERATORS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_word        = store_type'(ram_rd_data);
   assign ram_wr_data    = STORE_W'(wr_word);
   assign ram_rd_addr    = GEN_AW'(cmd_data.label);
   assign store_clearing = state_ff == ST_CLEAR;
   assign in_range       = 32'(cmd_ff.label) < 32'(MAX_GENERATORS);
   assign rsp_space      = !rsp_valid_ff || rsp_pop;

   assign mass_sum = {1'b0, rd_word.mass} + MASS_SUM_W'(cmd_ff.mass);
   assign xmom_sum = {1'b0, rd_word.xmom} + MOM_SUM_W'(cmd_ff.xmom);
   assign ymom_sum = {1'b0, acc_ff.ymom} + MOM_SUM_W'(yprod_ff);

   assign rsp_empty      = !rsp_valid_ff;
   assign rsp_read_index = rsp_index_ff;
   assign rsp_mass       = rsp_word_ff.mass;
   assign rsp_moment_x   = rsp_word_ff.xmom;
   assign rsp_moment_y   = rsp_word_ff.ymom;

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      cmd_in       = cmd_ff;
      acc_in       = acc_ff;
      yprod_in     = yprod_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_word_in  = rsp_word_ff;
      cmd_pop      = 1'b0;
      ram_rd_en    = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = GEN_AW'(cmd_ff.label);
      wr_word      = '0;

      if (rsp_pop && rsp_valid_ff) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            clr_addr_in = clr_addr_ff + GEN_AW'(1);
            if (clr_addr_ff == GEN_AW'(MAX_GENERATORS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop   = 1'b1;
               ram_rd_en = 1'b1;
               cmd_in    = cmd_data;
               state_in  = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (cmd_ff.kind == CMD_ADD) begin
               acc_in.mass = mass_sum[MASS_W] ? '1 : mass_sum[MASS_W-1:0];
               acc_in.xmom = xmom_sum[MOM_W] ? '1 : xmom_sum[MOM_W-1:0];
               acc_in.ymom = rd_word.ymom;
               yprod_in    = YPROD_W'(cmd_ff.row) * YPROD_W'(cmd_ff.mass);
               state_in    = ST_MERGE;
            end else if (rsp_space) begin
               // read data holds in the RAM output register while waiting
               rsp_valid_in = 1'b1;
               rsp_index_in = cmd_ff.label;
               rsp_word_in  = in_range ? rd_word : '0;
               ram_wr_en    = in_range && (cmd_ff.kind == CMD_READ_CLEAR);
               state_in     = ST_IDLE;
            end
         end
         ST_MERGE: begin
            wr_word.mass = acc_ff.mass;
            wr_word.xmom = acc_ff.xmom;
            wr_word.ymom = ymom_sum[MOM_W] ? '1 : ymom_sum[MOM_W-1:0];
            ram_wr_en    = in_range;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      acc_ff       <= acc_in;
      yprod_ff     <= yprod_in;
      rsp_index_ff <= rsp_index_in;
      rsp_word_ff  <= rsp_word_in;
   end

endmodule

`default_nettype wire

// ----- rtl/voronoi_centroid_span_accumulator_core.sv -----
// ----------------------------------------------------------------------------
// voronoi_centroid_span_accumulator_core
// Per-generator mass and moment accumulation over raster-order labeled pixels.
// ----------------------------------------------------------------------------
// A pixel is accepted whenever req_full is low. It costs more only when it
// closes a span: each close becomes a command for the accumulator, which does
// a read-modify-write of the generator's store entry in the steps read issue,
// lookup, and merge and write; a read has only read issue and lookup, and its
// lookup waits while the result register is full. A 4-entry command queue
// absorbs bursts, and a pixel that closes two spans at once (label change on
// the last column of a row) holds req_full while its second command waits.
// Sustained pixel rate is therefore one per cycle when spans average three or
// more pixels, and is bounded by the accumulator for one-pixel spans. After
// reset, req_full stays high while the store is swept to zero; configuration
// writes are taken during that time. Results wait in an output register, so
// pixels keep flowing while a read result is not yet popped, until a second
// read reaches the accumulator and the command queue fills up behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module voronoi_centroid_span_accumulator_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_push,
   output logic                                 req_full,
   input  wire logic [vcsa_pkg::OP_W-1:0]       req_opcode,
   input  wire logic [vcsa_pkg::DENS_W-1:0]     req_density,
   input  wire logic [vcsa_pkg::GEN_W-1:0]      req_generator_index,
   input  wire logic                            rsp_pop,
   output logic                                 rsp_empty,
   output logic [vcsa_pkg::GEN_W-1:0]           rsp_read_index,
   output logic [vcsa_pkg::MASS_W-1:0]          rsp_mass,
   output logic [vcsa_pkg::MOM_W-1:0]           rsp_moment_x,
   output logic [vcsa_pkg::MOM_W-1:0]           rsp_moment_y,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [vcsa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [vcsa_pkg::DIM_W-1:0]      csr_wdata
);

   import vcsa_pkg::*;

   logic    store_clearing;
   logic    cmdq_full, cmdq_empty;
   logic    cmd_push, cmd_pop;
   cmd_type cmd_in_data, cmd_out_data;

   vcsa_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_opcode          (req_opcode),
      .req_density         (req_density),
      .req_generator_index (req_generator_index),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .store_clearing      (store_clearing),
      .cmdq_full           (cmdq_full),
      .cmd_push            (cmd_push),
      .cmd_data            (cmd_in_data)
   );

   vcsa_cmd_fifo u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_data),
      .full      (cmdq_full),
      .pop       (cmd_pop),
      .empty     (cmdq_empty),
      .pop_data  (cmd_out_data)
   );

   vcsa_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_empty      (cmdq_empty),
      .cmd_data       (cmd_out_data),
      .cmd_pop        (cmd_pop),
      .store_clearing (store_clearing),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_read_index (rsp_read_index),
      .rsp_mass       (rsp_mass),
      .rsp_moment_x   (rsp_moment_x),
      .rsp_moment_y   (rsp_moment_y)
   );

endmodule

`default_nettype wire

// ----- rtl/vcsa_checker.sv -----
// ----------------------------------------------------------------------------
// vcsa_checker
// Port-level checks of the span accumulator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vcsa_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_full,
   input  wire logic                            rsp_pop,
   input  wire logic                            rsp_empty,
   input  wire logic [vcsa_pkg::GEN_W-1:0]      rsp_read_index,
   input  wire logic [vcsa_pkg::MASS_W-1:0]     rsp_mass,
   input  wire logic [vcsa_pkg::MOM_W-1:0]      rsp_moment_x,
   input  wire logic [vcsa_pkg::MOM_W-1:0]      rsp_moment_y
);

   // the store sweep keeps the input side closed right after reset
   assert property (@(posedge clock) reset |=> req_full)
      else $error("input not held off after reset");

   assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result pending after reset");

   // a waiting result is neither lost nor altered until its transfer
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_read_index)
         && $stable(rsp_mass) && $stable(rsp_moment_x) && $stable(rsp_moment_y)))
      else $error("pending result changed before transfer");

   // zero mass means every summed density was zero, so moments are zero too
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_mass == '0) |-> (rsp_moment_x == '0 && rsp_moment_y == '0))
      else $error("nonzero moment with zero mass");

endmodule

bind voronoi_centroid_span_accumulator_core vcsa_checker u_checker (.*);

`default_nettype wire
